// ===== hw/rtl/min_pool_downscale_macros.svh =====
// Assertion macros for the min-pooling downscaler.
// Included by the top level; depends on nothing else.
`ifndef MIN_POOL_DOWNSCALE_MACROS_SVH
`define MIN_POOL_DOWNSCALE_MACROS_SVH
`ifndef SYNTHESIS
`define MPD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("min_pool_downscale: check failed");
`define MPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("min_pool_downscale: check failed");
`else
`define MPD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MPD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/mpd_pkg.sv =====
// Shared types and constants of the min-pooling downscaler.
// Used by the top level, the front, the back and the testbench; depends on nothing.
package mpd_pkg;

  localparam int CFG_W     = 12;
  localparam int PIX_W     = 8;
  localparam int POS_W     = 11;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 4;
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

  localparam logic [CFG_W-1:0] RST_SRC_WIDTH  = 12'd640;
  localparam logic [CFG_W-1:0] RST_OUT_WIDTH  = 12'd320;
  localparam logic [CFG_W-1:0] RST_OUT_HEIGHT = 12'd240;
  localparam logic [CFG_W-1:0] RST_SCALE      = 12'd2;

  typedef enum logic [1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_OUT_WIDTH  = 2'd1,
    REG_OUT_HEIGHT = 2'd2,
    REG_SCALE      = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_value;
    logic [POS_W-1:0] out_col;
    logic [POS_W-1:0] out_row;
    logic             last_of_frame;
  } out_item_t;

  // One finished block row segment, handed from the front to the back.
  typedef struct packed {
    logic [PIX_W-1:0] run_min;
    logic             first_row;
    logic             last_row;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             last_of_frame;
  } op_t;

endpackage

// ===== hw/rtl/min_pool_downscale.sv =====
// Min-pooling grayscale downscaler. An op passes through the op queue and
// the back's stage register before a result is pushed to the output queue.
// Throughput: one pixel per cycle while the op queue has room, set by the
// line store's single read and write port. Reset (rst_n, synchronous)
// restores the register defaults and clears position counters and queues;
// the line store is not cleared, being written on each block's first row.
module min_pool_downscale #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Pixel input queue.
  input  logic                             push,
  input  mpd_pkg::in_item_t                in_data,
  output logic                             full,
  // Result output queue.
  input  logic                             pop,
  output mpd_pkg::out_item_t               out_data,
  output logic                             empty,
  // Register port.
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mpd_pkg::APB_AW-1:0]       paddr,
  input  logic [mpd_pkg::APB_DW-1:0]       pwdata,
  output logic [mpd_pkg::APB_DW-1:0]       prdata,
  output logic                             pready
);

  `include "min_pool_downscale_macros.svh"

  localparam int CW     = $clog2(MAX_WIDTH+1);
  localparam int IW     = $clog2(MAX_WIDTH);
  localparam int VW     = (CW > mpd_pkg::CFG_W) ? CW : mpd_pkg::CFG_W;
  localparam int OP_W   = $bits(mpd_pkg::op_t);
  localparam int MID_W  = IW + OP_W;
  localparam int OUT_W  = $bits(mpd_pkg::out_item_t);
  localparam int ONW    = $clog2(mpd_pkg::OUT_DEPTH+1);
  localparam int MNW    = $clog2(mpd_pkg::MID_DEPTH+1);

  // Registers hold what software wrote; the datapath sees the value clamped
  // to the range 1..MAX_WIDTH, with zero acting as one.
  function automatic logic [CW-1:0] eff(input logic [mpd_pkg::CFG_W-1:0] v);
    logic [VW-1:0] x;
    x = VW'(v);
    if (v == '0) begin
      return CW'(1);
    end
    if (x > VW'(MAX_WIDTH)) begin
      return CW'(MAX_WIDTH);
    end
    return CW'(x);
  endfunction

  logic [mpd_pkg::CFG_W-1:0] src_width_r, out_width_r, out_height_r, scale_r;
  logic                      cfg_wr;
  mpd_pkg::cfg_reg_t         reg_sel;

  logic                      in_acc;
  logic                      op_valid;
  mpd_pkg::op_t              op, q_op;
  logic [IW-1:0]             op_idx, q_idx;
  logic                      mid_full, mid_empty, mid_pop;
  logic [MID_W-1:0]          mid_rdata;
  logic [MNW-1:0]            mid_count;
  logic                      out_push, out_full;
  mpd_pkg::out_item_t        out_item;
  logic [OUT_W-1:0]          out_rdata;
  logic [ONW-1:0]            out_count;

  // Register port: zero-wait writes, reads decode the word address.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = mpd_pkg::cfg_reg_t'(paddr[3:2]);

  always_comb begin
    unique case (reg_sel)
      mpd_pkg::REG_SRC_WIDTH:  prdata = mpd_pkg::APB_DW'(src_width_r);
      mpd_pkg::REG_OUT_WIDTH:  prdata = mpd_pkg::APB_DW'(out_width_r);
      mpd_pkg::REG_OUT_HEIGHT: prdata = mpd_pkg::APB_DW'(out_height_r);
      mpd_pkg::REG_SCALE:      prdata = mpd_pkg::APB_DW'(scale_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= mpd_pkg::RST_SRC_WIDTH;
      out_width_r  <= mpd_pkg::RST_OUT_WIDTH;
      out_height_r <= mpd_pkg::RST_OUT_HEIGHT;
      scale_r      <= mpd_pkg::RST_SCALE;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        mpd_pkg::REG_SRC_WIDTH:  src_width_r  <= pwdata[mpd_pkg::CFG_W-1:0];
        mpd_pkg::REG_OUT_WIDTH:  out_width_r  <= pwdata[mpd_pkg::CFG_W-1:0];
        mpd_pkg::REG_OUT_HEIGHT: out_height_r <= pwdata[mpd_pkg::CFG_W-1:0];
        mpd_pkg::REG_SCALE:      scale_r      <= pwdata[mpd_pkg::CFG_W-1:0];
      endcase
    end
  end

  // The front takes a pixel whenever the op queue has room, so a stalled
  // result consumer only backs up once both queues have filled.
  assign full   = mid_full;
  assign in_acc = push && !full;

  mpd_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_acc),
    .item     (in_data),
    .eff_sw   (eff(src_width_r)),
    .eff_ow   (eff(out_width_r)),
    .eff_oh   (eff(out_height_r)),
    .eff_s    (eff(scale_r)),
    .op_valid (op_valid),
    .op       (op),
    .op_idx   (op_idx)
  );

  mpd_fifo #(.WIDTH(MID_W), .DEPTH(mpd_pkg::MID_DEPTH)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (op_valid),
    .wdata ({op_idx, op}),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty),
    .count (mid_count)
  );

  assign q_idx = mid_rdata[MID_W-1 -: IW];
  assign q_op  = mpd_pkg::op_t'(mid_rdata[OP_W-1:0]);

  mpd_back #(.MAX_WIDTH(MAX_WIDTH), .OUT_DEPTH(mpd_pkg::OUT_DEPTH)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (mid_empty),
    .q_op    (q_op),
    .q_idx   (q_idx),
    .q_pop   (mid_pop),
    .o_count (out_count),
    .o_push  (out_push),
    .o_item  (out_item)
  );

  mpd_fifo #(.WIDTH(OUT_W), .DEPTH(mpd_pkg::OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (out_push),
    .wdata (out_item),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty),
    .count (out_count)
  );

  assign out_data = mpd_pkg::out_item_t'(out_rdata);

  // The back's credit check must keep the result queue from overflowing.
  `MPD_ASSERT_IMP(a_out_no_overflow, clk, rst_n, out_push, !out_full)
  // An op is only produced for an accepted pixel, which needs queue room.
  `MPD_ASSERT_IMP(a_mid_no_overflow, clk, rst_n, op_valid, mid_count != MNW'(mpd_pkg::MID_DEPTH))
  // Taking the only waiting result with nothing arriving leaves the queue empty.
  `MPD_ASSERT_NEXT(a_out_drains, clk, rst_n, pop && (out_count == ONW'(1)) && !out_push, empty)

endmodule

// ===== hw/rtl/mpd_fifo.sv =====
// Small register-based queue with occupancy count.
// Used between the front and the back and on the result side; no package use.
module mpd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [WIDTH-1:0]             wdata,
  output logic                         full,
  input  logic                         pop,
  output logic [WIDTH-1:0]             rdata,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [NW-1:0]    count_r;
  logic             push_ok;
  logic             pop_ok;

  assign full    = (count_r == NW'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rdata   = mem_r[rd_ptr_r];
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count_r <= count_r + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/mpd_front.sv =====
// Front end: raster position tracking and running minimum along a block row.
// Depends on mpd_pkg; emits one op per finished block row segment in the output area.
module mpd_front #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               accept,
  input  mpd_pkg::in_item_t                  item,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]     eff_sw,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]     eff_ow,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]     eff_oh,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]     eff_s,
  output logic                               op_valid,
  output mpd_pkg::op_t                       op,
  output logic [$clog2(MAX_WIDTH)-1:0]       op_idx
);

  localparam int CW = $clog2(MAX_WIDTH+1);
  localparam int IW = $clog2(MAX_WIDTH);

  logic [IW-1:0]              src_col_r, src_col_nxt;
  logic [IW-1:0]              cib_r, cib_nxt;
  logic [IW-1:0]              rib_r, rib_nxt;
  logic [CW-1:0]              gc_r, gc_nxt;
  logic [CW-1:0]              gr_r, gr_nxt;
  logic [mpd_pkg::PIX_W-1:0]  run_min_r, run_min_nxt;

  logic [IW-1:0]              sc, cib, rib;
  logic [CW-1:0]              gc, gr;
  logic [mpd_pkg::PIX_W-1:0]  rm, px_min;
  logic                       active, end_col, last_row, row_end;

  always_comb begin
    // A frame start clears the position before this pixel is used.
    sc  = item.frame_start ? '0 : src_col_r;
    cib = item.frame_start ? '0 : cib_r;
    rib = item.frame_start ? '0 : rib_r;
    gc  = item.frame_start ? '0 : gc_r;
    gr  = item.frame_start ? '0 : gr_r;
    rm  = item.frame_start ? mpd_pkg::PIX_MAX : run_min_r;

    active   = (gr < eff_oh) && (gc < eff_ow);
    end_col  = (CW'(cib) + 1'b1) >= eff_s;
    last_row = (CW'(rib) + 1'b1) >= eff_s;
    row_end  = (CW'(sc) + 1'b1) >= eff_sw;
    px_min   = (item.pixel < rm) ? item.pixel : rm;

    op_valid         = accept && active && end_col;
    op.run_min       = px_min;
    op.first_row     = (rib == '0);
    op.last_row      = last_row;
    op.col           = mpd_pkg::POS_W'(gc);
    op.row           = mpd_pkg::POS_W'(gr);
    op.last_of_frame = (gc == eff_ow - 1'b1) && (gr == eff_oh - 1'b1);
    op_idx           = IW'(gc);

    run_min_nxt = active ? px_min : rm;
    if (active && end_col) begin
      run_min_nxt = mpd_pkg::PIX_MAX;
    end
    if (end_col) begin
      cib_nxt = '0;
      gc_nxt  = (gc < CW'(MAX_WIDTH)) ? gc + 1'b1 : gc;
    end else begin
      cib_nxt = cib + 1'b1;
      gc_nxt  = gc;
    end
    src_col_nxt = sc + 1'b1;
    rib_nxt     = rib;
    gr_nxt      = gr;
    if (row_end) begin
      src_col_nxt = '0;
      cib_nxt     = '0;
      gc_nxt      = '0;
      run_min_nxt = mpd_pkg::PIX_MAX;
      if (gr < eff_oh) begin
        if (last_row) begin
          rib_nxt = '0;
          gr_nxt  = gr + 1'b1;
        end else begin
          rib_nxt = rib + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_col_r <= '0;
      cib_r     <= '0;
      rib_r     <= '0;
      gc_r      <= '0;
      gr_r      <= '0;
      run_min_r <= mpd_pkg::PIX_MAX;
    end else if (accept) begin
      src_col_r <= src_col_nxt;
      cib_r     <= cib_nxt;
      rib_r     <= rib_nxt;
      gc_r      <= gc_nxt;
      gr_r      <= gr_nxt;
      run_min_r <= run_min_nxt;
    end
  end

endmodule

// ===== hw/rtl/mpd_back.sv =====
// Back end: line store of per-column partial minima and result forming.
// Depends on mpd_pkg; reads ops from the middle queue, writes the result queue.
module mpd_back #(
  parameter int MAX_WIDTH = 2048,
  parameter int OUT_DEPTH = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_empty,
  input  mpd_pkg::op_t                       q_op,
  input  logic [$clog2(MAX_WIDTH)-1:0]       q_idx,
  output logic                               q_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]     o_count,
  output logic                               o_push,
  output mpd_pkg::out_item_t                 o_item
);

  localparam int IW = $clog2(MAX_WIDTH);
  localparam int NW = $clog2(OUT_DEPTH+1) + 1;

  logic [mpd_pkg::PIX_W-1:0] line_mem [MAX_WIDTH];

  logic                      s1_valid_r;
  mpd_pkg::op_t              s1_op_r;
  logic [IW-1:0]             s1_idx_r;
  logic [mpd_pkg::PIX_W-1:0] rd_r;
  logic                      fwd_valid_r;
  logic [IW-1:0]             fwd_idx_r;
  logic [mpd_pkg::PIX_W-1:0] fwd_val_r;

  logic [mpd_pkg::PIX_W-1:0] stored, m;
  logic                      pending;

  // Only take an op when the result queue is sure to have room for it.
  assign pending = s1_valid_r && s1_op_r.last_row;
  assign q_pop   = !q_empty && ((NW'(o_count) + NW'(pending)) < NW'(OUT_DEPTH));

  always_comb begin
    // The entry written on the previous edge is not yet in the read data.
    stored = (fwd_valid_r && (fwd_idx_r == s1_idx_r)) ? fwd_val_r : rd_r;
    m      = s1_op_r.run_min;
    if (!s1_op_r.first_row && (stored < m)) begin
      m = stored;
    end
    o_push               = s1_valid_r && s1_op_r.last_row;
    o_item.out_value     = m;
    o_item.out_col       = s1_op_r.col;
    o_item.out_row       = s1_op_r.row;
    o_item.last_of_frame = s1_op_r.last_of_frame;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_r <= line_mem[q_idx];
    end
    if (s1_valid_r) begin
      line_mem[s1_idx_r] <= m;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_op_r  <= q_op;
      s1_idx_r <= q_idx;
    end
    if (s1_valid_r) begin
      fwd_idx_r <= s1_idx_r;
      fwd_val_r <= m;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= q_pop;
      if (s1_valid_r) begin
        fwd_valid_r <= 1'b1;
      end
    end
  end

endmodule

// ===== sim/min_pool_downscale_tb.sv =====
// Self-checking testbench for the min-pooling grayscale downscaler.
// Depends on mpd_pkg and the min_pool_downscale top level; needs nothing else.
module min_pool_downscale_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WIDTH     = 2048;
  localparam int IDX_W         = $clog2(MAX_WIDTH);
  // Margin after the results drain, covering the result path and internal queues.
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 400000;

  // Pixel values of the directed 4x4 frame, first pixel in the top byte.
  localparam logic [127:0] DIRECTED_PIXELS = {
    8'd200, 8'd255, 8'd90,  8'd255,
    8'd255, 8'd0,   8'd255, 8'd91,
    8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd254
  };

  logic                       clk     = 1'b0;
  logic                       rst_n   = 1'b0;
  logic                       push    = 1'b0;
  mpd_pkg::in_item_t          in_data = '0;
  logic                       full;
  logic                       pop     = 1'b0;
  mpd_pkg::out_item_t         out_data;
  logic                       empty;
  logic                       psel    = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite  = 1'b0;
  logic [mpd_pkg::APB_AW-1:0] paddr   = '0;
  logic [mpd_pkg::APB_DW-1:0] pwdata  = '0;
  logic [mpd_pkg::APB_DW-1:0] prdata;
  logic                       pready;

  min_pool_downscale #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_data  (in_data),
    .full     (full),
    .pop      (pop),
    .out_data (out_data),
    .empty    (empty),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state. It mirrors the block's position counters, the running
  // minimum of the current block row, the line store of partial column minima
  // and the four size registers.
  // ---------------------------------------------------------------------------
  logic [mpd_pkg::CFG_W-1:0] shadow_cfg [4];
  int unsigned               src_col;
  int unsigned               blk_col;
  int unsigned               blk_row;
  int unsigned               grp_col;
  int unsigned               grp_row;
  logic [mpd_pkg::PIX_W-1:0] row_min;
  logic [mpd_pkg::PIX_W-1:0] line_mins [MAX_WIDTH];

  // Block minima that the block still owes us, oldest first.
  mpd_pkg::out_item_t        pending_blocks [$];

  int unsigned      errors       = 0;
  int unsigned      pixels_taken = 0;
  int unsigned      cycles       = 0;
  int unsigned      burst_left   = 0;
  int unsigned      rx_mode      = 0;
  int unsigned      rx_left      = 0;

  // A register of zero behaves as one and anything past the line store
  // depth behaves as the depth.
  function automatic int unsigned eff_size(logic [mpd_pkg::CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_WIDTH) return MAX_WIDTH;
    return 32'(v);
  endfunction

  task automatic restart_frame();
    src_col = 0;
    blk_col = 0;
    blk_row = 0;
    grp_col = 0;
    grp_row = 0;
    row_min = mpd_pkg::PIX_MAX;
  endtask

  // Advances the predictor by one accepted pixel request and queues the
  // block minimum it completes, if any.
  task automatic pool_pixel(input mpd_pkg::in_item_t item);
    int unsigned               sw;
    int unsigned               ow;
    int unsigned               oh;
    int unsigned               s;
    logic [mpd_pkg::PIX_W-1:0] m;
    logic [IDX_W-1:0]          idx;
    mpd_pkg::out_item_t        res;
    sw = eff_size(shadow_cfg[mpd_pkg::REG_SRC_WIDTH]);
    ow = eff_size(shadow_cfg[mpd_pkg::REG_OUT_WIDTH]);
    oh = eff_size(shadow_cfg[mpd_pkg::REG_OUT_HEIGHT]);
    s  = eff_size(shadow_cfg[mpd_pkg::REG_SCALE]);
    // The pixel that carries the frame mark is already pixel (0,0).
    if (item.frame_start) restart_frame();
    if (grp_row < oh && grp_col < ow) begin
      if (item.pixel < row_min) row_min = item.pixel;
      if (blk_col + 1 >= s) begin
        // The first row of a block overwrites its line store entry; later
        // rows fold their running minimum into it.
        idx = IDX_W'(grp_col);
        m = row_min;
        if (blk_row != 0 && line_mins[idx] < m) m = line_mins[idx];
        line_mins[idx] = m;
        row_min = mpd_pkg::PIX_MAX;
        if (blk_row + 1 >= s) begin
          res.out_value     = m;
          res.out_col       = mpd_pkg::POS_W'(grp_col);
          res.out_row       = mpd_pkg::POS_W'(grp_row);
          res.last_of_frame = (grp_col == ow - 1) && (grp_row == oh - 1);
          pending_blocks.push_back(res);
        end
      end
    end
    if (blk_col + 1 >= s) begin
      blk_col = 0;
      if (grp_col < MAX_WIDTH) grp_col++;
    end else begin
      blk_col++;
    end
    src_col++;
    // Row end: columns past out_width*scale are dropped here, together with
    // any block cut off by the row end. Row counters hold once the frame is
    // complete.
    if (src_col >= sw) begin
      src_col = 0;
      blk_col = 0;
      grp_col = 0;
      row_min = mpd_pkg::PIX_MAX;
      if (grp_row < oh) begin
        if (blk_row + 1 >= s) begin
          blk_row = 0;
          grp_row++;
        end else begin
          blk_row++;
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("ERROR at cycle %0d: %s: got %0d, expected %0d", cycles, what, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor. Everything is sampled right after the rising edge, so the values
  // seen are the ones the block saw at that edge. Register writes, pixel
  // requests and result requests are handled in one process, in that order,
  // so that nothing depends on the order of processes within a time step.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    mpd_pkg::out_item_t want;
    if (!rst_n) begin
      shadow_cfg[mpd_pkg::REG_SRC_WIDTH]  = mpd_pkg::RST_SRC_WIDTH;
      shadow_cfg[mpd_pkg::REG_OUT_WIDTH]  = mpd_pkg::RST_OUT_WIDTH;
      shadow_cfg[mpd_pkg::REG_OUT_HEIGHT] = mpd_pkg::RST_OUT_HEIGHT;
      shadow_cfg[mpd_pkg::REG_SCALE]      = mpd_pkg::RST_SCALE;
      restart_frame();
    end else begin
      if (psel && penable && pwrite && pready)
        shadow_cfg[mpd_pkg::cfg_reg_t'(paddr[3:2])] = pwdata[mpd_pkg::CFG_W-1:0];
      if (push && !full) begin
        pool_pixel(in_data);
        pixels_taken++;
      end
      if (pop && !empty) begin
        if (pending_blocks.size() == 0) begin
          report_mismatch("result with nothing pending, value",
                          32'(out_data.out_value), 0);
        end else begin
          want = pending_blocks.pop_front();
          if (out_data.out_value !== want.out_value)
            report_mismatch("out_value", 32'(out_data.out_value), 32'(want.out_value));
          if (out_data.out_col !== want.out_col)
            report_mismatch("out_col", 32'(out_data.out_col), 32'(want.out_col));
          if (out_data.out_row !== want.out_row)
            report_mismatch("out_row", 32'(out_data.out_row), 32'(want.out_row));
          if (out_data.last_of_frame !== want.last_of_frame)
            report_mismatch("last_of_frame", 32'(out_data.last_of_frame),
                            32'(want.last_of_frame));
        end
      end
    end
  end

  // The receiver stalls on its own pattern: always ready, coin flips, a
  // fixed one-in-four rhythm, or long random stalls. The mode is redrawn
  // when its random countdown runs out, so stalls hit every phase of a frame.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(50, 400);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0:       pop <= 1'b1;
      1:       pop <= 1'(($urandom_range(0, 1)));
      2:       pop <= (rx_left % 4 == 0);
      default: pop <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Register port. Each transfer ends by dropping psel and idling the bus.
  // ---------------------------------------------------------------------------
  task automatic apb_write(input mpd_pkg::cfg_reg_t r,
                           input logic [mpd_pkg::CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= mpd_pkg::APB_AW'(4 * int'(r));
    pwdata  <= mpd_pkg::APB_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(input mpd_pkg::cfg_reg_t r,
                          output logic [mpd_pkg::APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= mpd_pkg::APB_AW'(4 * int'(r));
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    value   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_geometry(input logic [mpd_pkg::CFG_W-1:0] sw,
                              input logic [mpd_pkg::CFG_W-1:0] ow,
                              input logic [mpd_pkg::CFG_W-1:0] oh,
                              input logic [mpd_pkg::CFG_W-1:0] s);
    apb_write(mpd_pkg::REG_SRC_WIDTH, sw);
    apb_write(mpd_pkg::REG_OUT_WIDTH, ow);
    apb_write(mpd_pkg::REG_OUT_HEIGHT, oh);
    apb_write(mpd_pkg::REG_SCALE, s);
  endtask

  // ---------------------------------------------------------------------------
  // Pixel sender. One request is offered until the block takes it; then the
  // sender either keeps push high for the next request or, at the end of a
  // burst, drops it for a random gap.
  // ---------------------------------------------------------------------------
  task automatic send_pixel(input logic [mpd_pkg::PIX_W-1:0] px, input logic fs);
    push    <= 1'b1;
    in_data <= {px, fs};
    do @(posedge clk); while (full);
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      // Now and then a long burst with no idling at all.
      if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(100, 300);
      else burst_left = $urandom_range(0, 20);
    end
  endtask

  // Waits until every block minimum owed has been taken. The first edge is
  // always waited for, so the request accepted at the current edge is
  // already counted.
  task automatic wait_results();
    push <= 1'b0;
    do @(posedge clk); while (pending_blocks.size() != 0);
  endtask

  // Idle point for register writes: results drained and the pipeline given
  // time to finish pixels that complete no block.
  task automatic wait_drained();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [mpd_pkg::PIX_W-1:0] rand_pixel(input int unsigned flavor);
    case (flavor)
      0:       return mpd_pkg::PIX_W'($urandom_range(0, 255));
      1:       return mpd_pkg::PIX_W'($urandom_range(192, 255));
      2:       return ($urandom_range(0, 1) != 0) ? mpd_pkg::PIX_MAX : '0;
      default: return ($urandom_range(0, 3) == 0) ? mpd_pkg::PIX_W'($urandom_range(0, 255))
                                                  : mpd_pkg::PIX_MAX;
    endcase
  endfunction

  // Sends one frame in raster order, sometimes with discarded rows below it.
  // About one frame in ten is broken: it either stops early or carries a
  // second frame mark part way through.
  task automatic stream_frame(input int unsigned sw, input int unsigned ow,
                              input int unsigned oh, input int unsigned s);
    int unsigned rows;
    int unsigned total;
    int unsigned cut;
    int unsigned flavor;
    bit          broken;
    bit          restart;
    rows    = oh * s + (($urandom_range(0, 3) == 0) ? $urandom_range(1, s) : 0);
    total   = rows * sw;
    broken  = (total > 1) && ($urandom_range(0, 9) == 0);
    restart = 1'($urandom_range(0, 1));
    cut     = (total > 1) ? $urandom_range(1, total - 1) : 0;
    flavor  = $urandom_range(0, 3);
    for (int unsigned i = 0; i < total; i++) begin
      if (broken && !restart && i == cut) return;
      send_pixel(rand_pixel(flavor), (i == 0) || (broken && restart && i == cut));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Reset values read back, then two complementary patterns per register so
  // that every register bit is written and read as both zero and one.
  task automatic test_register_access();
    logic [mpd_pkg::APB_DW-1:0] rd;
    apb_read(mpd_pkg::REG_SRC_WIDTH, rd);
    if (rd[mpd_pkg::CFG_W-1:0] !== mpd_pkg::RST_SRC_WIDTH)
      report_mismatch("src_width reset", rd, 32'(mpd_pkg::RST_SRC_WIDTH));
    apb_read(mpd_pkg::REG_OUT_WIDTH, rd);
    if (rd[mpd_pkg::CFG_W-1:0] !== mpd_pkg::RST_OUT_WIDTH)
      report_mismatch("out_width reset", rd, 32'(mpd_pkg::RST_OUT_WIDTH));
    apb_read(mpd_pkg::REG_OUT_HEIGHT, rd);
    if (rd[mpd_pkg::CFG_W-1:0] !== mpd_pkg::RST_OUT_HEIGHT)
      report_mismatch("out_height reset", rd, 32'(mpd_pkg::RST_OUT_HEIGHT));
    apb_read(mpd_pkg::REG_SCALE, rd);
    if (rd[mpd_pkg::CFG_W-1:0] !== mpd_pkg::RST_SCALE)
      report_mismatch("scale_factor reset", rd, 32'(mpd_pkg::RST_SCALE));
    for (int p = 0; p < 2; p++) begin
      for (int r = 0; r < 4; r++) begin
        apb_write(mpd_pkg::cfg_reg_t'(r), (p == 0) ? 12'hA5A : 12'h5A5);
        apb_read(mpd_pkg::cfg_reg_t'(r), rd);
        if (rd[mpd_pkg::CFG_W-1:0] !== ((p == 0) ? 12'hA5A : 12'h5A5))
          report_mismatch("register readback", 32'(rd[mpd_pkg::CFG_W-1:0]),
                          32'((p == 0) ? 12'hA5A : 12'h5A5));
      end
    end
  endtask

  // A short hand-made sequence on a 4x4 source with 2x2 blocks: a frame that
  // is cut off by a new frame mark, one full frame with block minima of 0, 90,
  // 255 and 254, and pixels after the frame that must be ignored.
  task automatic test_directed_frame();
    wait_drained();
    set_geometry(4, 2, 2, 2);
    send_pixel(8'h00, 1'b1);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h01, 1'b0);
    send_pixel(8'h80, 1'b0);
    send_pixel(8'h7F, 1'b0);
    for (int i = 0; i < 16; i++)
      send_pixel(DIRECTED_PIXELS[7'(127 - 8 * i) -: 8], i == 0);
    repeat (3) send_pixel(8'h00, 1'b0);
  endtask

  // Mostly well-formed frames on small random geometries where the source
  // width is out_width*scale plus fewer than scale extra columns, with broken
  // frames and stray pixels mixed in.
  task automatic test_random_frames(input int unsigned quota);
    int unsigned s;
    int unsigned ow;
    int unsigned oh;
    int unsigned sw;
    int unsigned start;
    start = pixels_taken;
    while (pixels_taken - start < quota) begin
      s  = $urandom_range(1, 4);
      ow = $urandom_range(1, 6);
      oh = $urandom_range(1, 4);
      sw = ow * s + $urandom_range(0, s - 1);
      wait_drained();
      set_geometry(mpd_pkg::CFG_W'(sw), mpd_pkg::CFG_W'(ow), mpd_pkg::CFG_W'(oh),
                   mpd_pkg::CFG_W'(s));
      repeat ($urandom_range(1, 3)) stream_frame(sw, ow, oh, s);
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 4)) send_pixel(rand_pixel(0), 1'b0);
    end
  endtask

  // Source rows shorter than out_width*scale: the block cut off by the row
  // end must be dropped and its running minimum must not leak into the
  // next row.
  task automatic test_inconsistent_sizes(input int unsigned quota);
    int unsigned s;
    int unsigned ow;
    int unsigned oh;
    int unsigned sw;
    int unsigned start;
    start = pixels_taken;
    while (pixels_taken - start < quota) begin
      s  = $urandom_range(2, 4);
      ow = $urandom_range(2, 5);
      oh = $urandom_range(1, 3);
      sw = $urandom_range(1, ow * s - 1);
      wait_drained();
      set_geometry(mpd_pkg::CFG_W'(sw), mpd_pkg::CFG_W'(ow), mpd_pkg::CFG_W'(oh),
                   mpd_pkg::CFG_W'(s));
      repeat ($urandom_range(1, 2)) stream_frame(sw, ow, oh, s);
    end
  endtask

  // Registers at zero (acting as one) and above the line store depth
  // (acting as the depth), including the depth itself.
  task automatic test_register_extremes();
    wait_drained();
    set_geometry(0, 0, 0, 0);
    // Every frame is a single pixel; the pixel after it is ignored.
    repeat (6) begin
      send_pixel(rand_pixel(0), 1'b1);
      send_pixel(rand_pixel(0), 1'b0);
    end
    wait_drained();
    set_geometry(5, 12'hFFF, 12'hFFF, 1);
    for (int i = 0; i < 30; i++) send_pixel(rand_pixel(0), i == 0);
    wait_drained();
    // A block edge of the full depth never completes on a short row.
    set_geometry(3, 1, 1, 12'hFFF);
    for (int i = 0; i < 20; i++) send_pixel(rand_pixel(0), i == 0);
    wait_drained();
    set_geometry(12'hFFF, 3, 2, 1);
    for (int i = 0; i < 40; i++) send_pixel(rand_pixel(0), i == 0);
    wait_drained();
    set_geometry(6, 2, mpd_pkg::CFG_W'(MAX_WIDTH), 3);
    for (int i = 0; i < 36; i++) send_pixel(rand_pixel(0), i == 0);
  endtask

  // The sender stops part way through a frame until every owed result has
  // arrived, then carries on with the same frame.
  task automatic test_drain_pause();
    int unsigned hold;
    wait_drained();
    set_geometry(8, 4, 2, 2);
    repeat (3) begin
      hold = $urandom_range(1, 30);
      for (int unsigned i = 0; i < 32; i++) begin
        if (i == hold) wait_results();
        send_pixel(rand_pixel(0), i == 0);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_access();
    test_directed_frame();
    test_random_frames(1000);
    test_inconsistent_sizes(300);
    test_register_extremes();
    test_drain_pause();
    wait_drained();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
